// ===== rtl/core/ecb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ecb_pkg;

    // Operation codes carried in the request.
    localparam logic [1:0] OP_SET       = 2'd0;
    localparam logic [1:0] OP_SET_CLAMP = 2'd1;
    localparam logic [1:0] OP_ROTATE    = 2'd2;

    // Angle units are 1/64 degree.
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int PITCH_LIMIT  = 5696;

    // CORDIC datapath widths and start value (gain-compensated 1.0 in Q2.30).
    localparam int XY_W = 33;
    localparam int Z_W  = 25;
    localparam int ATAN_W = 23;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;

    // Q1.14 unity.
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    // Sine and cosine of one angle, as handed from the CORDIC unit.
    typedef struct packed {
        logic signed [15:0] sin_val;
        logic signed [15:0] cos_val;
    } ecb_trig_t;

    // Arctangent of 2^-i in degrees * 2^16, rounded to nearest.
    function automatic logic [ATAN_W-1:0] atan_deg16(input logic [4:0] idx);
        logic [ATAN_W-1:0] val;
        begin
            unique case (idx)
                5'd0:    val = 23'd2949120;
                5'd1:    val = 23'd1740967;
                5'd2:    val = 23'd919879;
                5'd3:    val = 23'd466945;
                5'd4:    val = 23'd234379;
                5'd5:    val = 23'd117304;
                5'd6:    val = 23'd58666;
                5'd7:    val = 23'd29335;
                5'd8:    val = 23'd14668;
                5'd9:    val = 23'd7334;
                5'd10:   val = 23'd3667;
                5'd11:   val = 23'd1833;
                5'd12:   val = 23'd917;
                5'd13:   val = 23'd458;
                5'd14:   val = 23'd229;
                5'd15:   val = 23'd115;
                5'd16:   val = 23'd57;
                5'd17:   val = 23'd29;
                5'd18:   val = 23'd14;
                5'd19:   val = 23'd7;
                5'd20:   val = 23'd4;
                5'd21:   val = 23'd2;
                5'd22:   val = 23'd1;
                default: val = 23'd0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ecb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel: an operation and three angles.
interface ecb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [15:0] x_angle;
    logic signed [15:0] y_angle;
    logic signed [15:0] z_angle;

    modport source (output valid, output operation, output x_angle, output y_angle,
                    output z_angle, input ready);
    modport sink   (input valid, input operation, input x_angle, input y_angle,
                    input z_angle, output ready);
endinterface

// Result channel: the camera basis vectors and the stored roll.
interface ecb_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] roll_now;

    modport source (output valid, output front_x, output front_y, output front_z,
                    output right_x, output right_y, output right_z, output up_x,
                    output up_y, output up_z, output roll_now, input ready);
    modport sink   (input valid, input front_x, input front_y, input front_z,
                    input right_x, input right_y, input right_z, input up_x,
                    input up_y, input up_z, input roll_now, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ecb_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Iterative rotation-mode CORDIC giving sine and cosine of one angle in Q1.14.
// The angle is reduced to a quadrant and a remainder, then rotated one
// micro-rotation per clock.
module ecb_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic signed [15:0] angle,
    output ecb_pkg::ecb_trig_t     trig,
    output logic                   done
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    typedef enum logic [4:0] {
        C_IDLE   = 5'b00001,
        C_REDUCE = 5'b00010,
        C_QUAD   = 5'b00100,
        C_ITER   = 5'b01000,
        C_ROUND  = 5'b10000
    } cstate_t;

    cstate_t                              state_reg, state_next;
    logic signed [15:0]                   angle_reg;
    logic [14:0]                          mod_reg;
    logic [1:0]                           quad_reg;
    logic [STEP_W-1:0]                    step_reg;
    logic signed [ecb_pkg::XY_W-1:0]      x_reg, y_reg, x_next, y_next;
    logic signed [ecb_pkg::Z_W-1:0]       z_reg, z_next;
    ecb_pkg::ecb_trig_t                   trig_reg;
    logic                                 done_reg;

    // Angle reduction into one full turn, offset to keep it positive.
    logic signed [17:0] shifted;
    logic [16:0]        unwrapped;
    logic [14:0]        mod_val;

    // Quadrant split.
    logic [1:0]  quad_val;
    logic [12:0] rem_val;

    // Micro-rotation terms.
    logic signed [ecb_pkg::XY_W-1:0] x_shift, y_shift;
    logic signed [ecb_pkg::Z_W-1:0]  atan_val;

    // Rounding to Q1.14.
    logic signed [ecb_pkg::XY_W-1:0] x_rnd, y_rnd;
    logic signed [16:0]              c_raw, s_raw;
    logic signed [15:0]              c_sat, s_sat;
    ecb_pkg::ecb_trig_t              trig_map;

    function automatic logic signed [15:0] sat_q14(input logic signed [16:0] v);
        logic signed [15:0] r;
        begin
            if (v > 17'sd16384)
                r = ecb_pkg::Q14_ONE;
            else if (v < -17'sd16384)
                r = -ecb_pkg::Q14_ONE;
            else
                r = v[15:0];
            return r;
        end
    endfunction

    // Reduce the angle modulo a full turn with three parallel compares.
    always_comb
    begin
        shifted   = 18'(angle_reg) + 18'sd46080;
        unwrapped = shifted[16:0];
        if (unwrapped >= 17'd69120)
            mod_val = 15'(unwrapped - 17'd69120);
        else if (unwrapped >= 17'd46080)
            mod_val = 15'(unwrapped - 17'd46080);
        else if (unwrapped >= 17'(ecb_pkg::FULL_TURN))
            mod_val = 15'(unwrapped - 17'(ecb_pkg::FULL_TURN));
        else
            mod_val = unwrapped[14:0];
    end

    // Split the reduced angle into quadrant and remainder.
    always_comb
    begin
        if (mod_reg < 15'(ecb_pkg::QUARTER_TURN))
        begin
            quad_val = 2'd0;
            rem_val  = mod_reg[12:0];
        end
        else if (mod_reg < 15'd11520)
        begin
            quad_val = 2'd1;
            rem_val  = 13'(mod_reg - 15'(ecb_pkg::QUARTER_TURN));
        end
        else if (mod_reg < 15'd17280)
        begin
            quad_val = 2'd2;
            rem_val  = 13'(mod_reg - 15'd11520);
        end
        else
        begin
            quad_val = 2'd3;
            rem_val  = 13'(mod_reg - 15'd17280);
        end
    end

    // One micro-rotation; the sign of the residual angle picks the direction.
    always_comb
    begin
        x_shift  = x_reg >>> step_reg;
        y_shift  = y_reg >>> step_reg;
        atan_val = ecb_pkg::Z_W'({2'b00, ecb_pkg::atan_deg16(5'(step_reg))});
        if (!z_reg[ecb_pkg::Z_W-1])
        begin
            x_next = x_reg - y_shift;
            y_next = y_reg + x_shift;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + y_shift;
            y_next = y_reg - x_shift;
            z_next = z_reg + atan_val;
        end
    end

    // Round to Q1.14, saturate and map back by quadrant.
    always_comb
    begin
        x_rnd = x_reg + 33'sd32768;
        y_rnd = y_reg + 33'sd32768;
        c_raw = x_rnd[32:16];
        s_raw = y_rnd[32:16];
        c_sat = sat_q14(c_raw);
        s_sat = sat_q14(s_raw);
        unique case (quad_reg)
            2'd0:
            begin
                trig_map.cos_val = c_sat;
                trig_map.sin_val = s_sat;
            end
            2'd1:
            begin
                trig_map.cos_val = -s_sat;
                trig_map.sin_val = c_sat;
            end
            2'd2:
            begin
                trig_map.cos_val = -c_sat;
                trig_map.sin_val = -s_sat;
            end
            default:
            begin
                trig_map.cos_val = s_sat;
                trig_map.sin_val = -c_sat;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:   if (start) state_next = C_REDUCE;
            C_REDUCE: state_next = C_QUAD;
            C_QUAD:   state_next = C_ITER;
            C_ITER:   if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = C_ROUND;
            C_ROUND:  state_next = C_IDLE;
            default:  state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_ROUND);
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                    angle_reg <= angle;
            end
            C_REDUCE:
            begin
                mod_reg <= mod_val;
            end
            C_QUAD:
            begin
                quad_reg <= quad_val;
                x_reg    <= ecb_pkg::CORDIC_X0;
                y_reg    <= '0;
                z_reg    <= ecb_pkg::Z_W'({rem_val, 10'b0});
                step_reg <= '0;
            end
            C_ITER:
            begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                z_reg    <= z_next;
                step_reg <= step_reg + 1'b1;
            end
            C_ROUND:
            begin
                trig_reg <= trig_map;
            end
            default:
            begin
            end
        endcase
    end

    assign trig = trig_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/euler_to_camera_basis.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Camera basis from stored yaw, pitch and roll (1/64 degree units). Each request
// sets the three angles, sets them with pitch held to within 89 degrees, adds
// a saturating delta to roll, or (unused code) changes nothing; the block then
// returns front, right and up unit vectors in Q1.14 for the stored yaw and pitch,
// together with the stored roll. A single shared CORDIC unit runs yaw and then
// pitch at one micro-rotation per clock, and one shared multiplier forms the four
// products in turn. A new request is taken once the previous one is finished,
// even while its result still waits in the output register.
module euler_to_camera_basis #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ecb_in_if.sink      cmd,
    ecb_out_if.source   basis
);

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_YAW_GO     = 7'b0000010,
        ST_YAW_WAIT   = 7'b0000100,
        ST_PITCH_GO   = 7'b0001000,
        ST_PITCH_WAIT = 7'b0010000,
        ST_MUL        = 7'b0100000,
        ST_DONE       = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic signed [15:0] yaw_reg, pitch_reg, roll_reg;
    logic signed [15:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [15:0] fx_reg, fz_reg, ux_reg, uz_reg;
    logic [1:0]         mul_sel_reg;
    logic               out_valid_reg;
    logic signed [15:0] o_front_x_reg, o_front_y_reg, o_front_z_reg;
    logic signed [15:0] o_right_x_reg, o_right_z_reg;
    logic signed [15:0] o_up_x_reg, o_up_y_reg, o_up_z_reg, o_roll_reg;

    logic               accept;
    logic               cordic_start;
    logic signed [15:0] cordic_angle;
    ecb_pkg::ecb_trig_t cordic_trig;
    logic               cordic_done;
    logic               load_out;

    logic signed [15:0] pitch_clamped;
    logic signed [16:0] roll_sum;
    logic signed [15:0] roll_sat;

    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] mul_prod, mul_rnd;
    logic signed [15:0] mul_res;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    // Pitch limit for the clamped set operation.
    always_comb
    begin
        if (cmd.y_angle > 16'(ecb_pkg::PITCH_LIMIT))
            pitch_clamped = 16'(ecb_pkg::PITCH_LIMIT);
        else if (cmd.y_angle < -16'sd5696)
            pitch_clamped = -16'sd5696;
        else
            pitch_clamped = cmd.y_angle;
    end

    // Saturating roll update.
    always_comb
    begin
        roll_sum = 17'(roll_reg) + 17'(cmd.z_angle);
        if (roll_sum[16] != roll_sum[15])
            roll_sat = roll_sum[16] ? -16'sd32768 : 16'sd32767;
        else
            roll_sat = roll_sum[15:0];
    end

    // Stored angles.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
            roll_reg  <= '0;
        end
        else if (accept)
        begin
            priority if (cmd.operation == ecb_pkg::OP_SET)
            begin
                yaw_reg   <= cmd.x_angle;
                pitch_reg <= cmd.y_angle;
                roll_reg  <= cmd.z_angle;
            end
            else if (cmd.operation == ecb_pkg::OP_SET_CLAMP)
            begin
                yaw_reg   <= cmd.x_angle;
                pitch_reg <= pitch_clamped;
                roll_reg  <= cmd.z_angle;
            end
            else if (cmd.operation == ecb_pkg::OP_ROTATE)
            begin
                roll_reg <= roll_sat;
            end
            else
            begin
            end
        end
    end

    // Shared sine and cosine unit, fed yaw and then pitch.
    assign cordic_start = (state_reg == ST_YAW_GO) || (state_reg == ST_PITCH_GO);
    assign cordic_angle = (state_reg == ST_YAW_GO) ? yaw_reg : pitch_reg;

    ecb_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (cordic_angle),
        .trig  (cordic_trig),
        .done  (cordic_done)
    );

    // Shared Q1.14 multiplier with round-half-up.
    always_comb
    begin
        mul_a    = mul_sel_reg[1] ? sp_reg : cp_reg;
        mul_b    = mul_sel_reg[0] ? cy_reg : sy_reg;
        mul_prod = mul_a * mul_b;
        mul_rnd  = mul_prod + 32'sd8192;
        mul_res  = mul_rnd[29:14];
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || basis.ready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (accept) state_next = ST_YAW_GO;
            ST_YAW_GO:     state_next = ST_YAW_WAIT;
            ST_YAW_WAIT:   if (cordic_done) state_next = ST_PITCH_GO;
            ST_PITCH_GO:   state_next = ST_PITCH_WAIT;
            ST_PITCH_WAIT: if (cordic_done) state_next = ST_MUL;
            ST_MUL:        if (mul_sel_reg == 2'd3) state_next = ST_DONE;
            ST_DONE:       if (load_out) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_sel_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
                mul_sel_reg <= mul_sel_reg + 1'b1;
            else
                mul_sel_reg <= '0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (basis.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Trig values and products.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_YAW_WAIT) && cordic_done)
        begin
            sy_reg <= cordic_trig.sin_val;
            cy_reg <= cordic_trig.cos_val;
        end
        if ((state_reg == ST_PITCH_WAIT) && cordic_done)
        begin
            sp_reg <= cordic_trig.sin_val;
            cp_reg <= cordic_trig.cos_val;
        end
        if (state_reg == ST_MUL)
        begin
            unique case (mul_sel_reg)
                2'd0:    fx_reg <= mul_res;
                2'd1:    fz_reg <= mul_res;
                2'd2:    ux_reg <= mul_res;
                default: uz_reg <= mul_res;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_front_x_reg <= fx_reg;
            o_front_y_reg <= -sp_reg;
            o_front_z_reg <= fz_reg;
            o_right_x_reg <= -cy_reg;
            o_right_z_reg <= sy_reg;
            o_up_x_reg    <= ux_reg;
            o_up_y_reg    <= cp_reg;
            o_up_z_reg    <= uz_reg;
            o_roll_reg    <= roll_reg;
        end
    end

    assign basis.valid    = out_valid_reg;
    assign basis.front_x  = o_front_x_reg;
    assign basis.front_y  = o_front_y_reg;
    assign basis.front_z  = o_front_z_reg;
    assign basis.right_x  = o_right_x_reg;
    assign basis.right_y  = '0;
    assign basis.right_z  = o_right_z_reg;
    assign basis.up_x     = o_up_x_reg;
    assign basis.up_y     = o_up_y_reg;
    assign basis.up_z     = o_up_z_reg;
    assign basis.roll_now = o_roll_reg;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import ecb_pkg::*;

    localparam int STEPS = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint ROTATOR_START = 64'sd652032874;

    // One expected result: the three basis vectors and the stored roll.
    typedef struct {
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] roll_now;
    } basis_t;

    logic clk;
    logic rst_n;

    // Arctangent of 2^-i in degrees scaled by 2^16.
    longint micro_angle [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // Angles as the block should hold them after every accepted request.
    logic signed [15:0] yaw_q;
    logic signed [15:0] pitch_q;
    logic signed [15:0] roll_q;

    basis_t pending_basis [$];
    int     fail_count;
    int     send_gap_pct;
    int     recv_gap_pct;
    int     recv_hold;

    ecb_in_if  cmd_if ();
    ecb_out_if basis_if ();

    euler_to_camera_basis #(
        .CORDIC_STEPS(STEPS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_if),
        .basis(basis_if)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    // Rounds a Q2.30 rotator output to Q1.14 and holds it within unity.
    function automatic longint round_to_q14(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 16384)
            r = 16384;
        else if (r < -16384)
            r = -16384;
        return r;
    endfunction

    // Product of two Q1.14 values, rounded half up.
    function automatic logic signed [15:0] q14_product(input logic signed [15:0] a,
                                                        input logic signed [15:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd8192;
        return 16'(p >>> 14);
    endfunction

    // Sine and cosine of an angle: fold into one quadrant, rotate, then unfold.
    function automatic ecb_trig_t trig_of(input logic signed [15:0] angle);
        ecb_trig_t tr;
        int        m;
        int        quad;
        int        rem;
        longint    x;
        longint    y;
        longint    z;
        longint    nx;
        longint    c;
        longint    s;
        m = int'(angle) % FULL_TURN;
        if (m < 0)
            m += FULL_TURN;
        quad = m / QUARTER_TURN;
        rem  = m - quad * QUARTER_TURN;
        x = ROTATOR_START;
        y = 0;
        z = longint'(rem) * 1024;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - micro_angle[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + micro_angle[i];
            end
            x = nx;
        end
        c = round_to_q14(x);
        s = round_to_q14(y);
        case (quad)
            0:
            begin
                tr.cos_val = 16'(c);
                tr.sin_val = 16'(s);
            end
            1:
            begin
                tr.cos_val = 16'(-s);
                tr.sin_val = 16'(c);
            end
            2:
            begin
                tr.cos_val = 16'(-c);
                tr.sin_val = 16'(-s);
            end
            default:
            begin
                tr.cos_val = 16'(s);
                tr.sin_val = 16'(-c);
            end
        endcase
        return tr;
    endfunction

    // Applies one request to the held angles and works out the basis it yields.
    function automatic basis_t predict_basis(input logic [1:0] op,
                                             input logic signed [15:0] xa,
                                             input logic signed [15:0] ya,
                                             input logic signed [15:0] za);
        basis_t    res;
        ecb_trig_t yaw_t;
        ecb_trig_t pitch_t;
        int        p;
        int        sum;
        if (op == OP_SET || op == OP_SET_CLAMP)
        begin
            p = int'(ya);
            if (op == OP_SET_CLAMP && p > PITCH_LIMIT)
                p = PITCH_LIMIT;
            else if (op == OP_SET_CLAMP && p < -PITCH_LIMIT)
                p = -PITCH_LIMIT;
            yaw_q   = xa;
            pitch_q = 16'(p);
            roll_q  = za;
        end
        else if (op == OP_ROTATE)
        begin
            sum = int'(roll_q) + int'(za);
            if (sum > 32767)
                sum = 32767;
            else if (sum < -32768)
                sum = -32768;
            roll_q = 16'(sum);
        end
        yaw_t   = trig_of(yaw_q);
        pitch_t = trig_of(pitch_q);
        res.front_x  = q14_product(pitch_t.cos_val, yaw_t.sin_val);
        res.front_y  = -pitch_t.sin_val;
        res.front_z  = q14_product(pitch_t.cos_val, yaw_t.cos_val);
        res.right_x  = -yaw_t.cos_val;
        res.right_y  = '0;
        res.right_z  = yaw_t.sin_val;
        res.up_x     = q14_product(pitch_t.sin_val, yaw_t.sin_val);
        res.up_y     = pitch_t.cos_val;
        res.up_z     = q14_product(pitch_t.sin_val, yaw_t.cos_val);
        res.roll_now = roll_q;
        return res;
    endfunction

    // Angle for random requests: anywhere, near a quadrant edge, small, or near the pitch limit.
    function automatic logic signed [15:0] pick_angle();
        int kind;
        int val;
        kind = $urandom_range(3);
        case (kind)
            0:       val = int'($urandom_range(65535)) - 32768;
            1:       val = (int'($urandom_range(10)) - 5) * QUARTER_TURN
                           + int'($urandom_range(6)) - 3;
            2:       val = int'($urandom_range(400)) - 200;
            default: val = ($urandom_range(1) ? PITCH_LIMIT : -PITCH_LIMIT)
                           + int'($urandom_range(8)) - 4;
        endcase
        return 16'(val);
    endfunction

    // Sends one request, called at a falling edge; returns at the falling edge after
    // acceptance with valid still high, so back-to-back requests need no gap.
    task automatic issue_request(input logic [1:0] op,
                                 input logic signed [15:0] xa,
                                 input logic signed [15:0] ya,
                                 input logic signed [15:0] za);
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_if.valid     = 1'b0;
            cmd_if.operation = 2'($urandom);
            cmd_if.x_angle   = 16'($urandom);
            cmd_if.y_angle   = 16'($urandom);
            cmd_if.z_angle   = 16'($urandom);
            @(negedge clk);
        end
        cmd_if.valid     = 1'b1;
        cmd_if.operation = op;
        cmd_if.x_angle   = xa;
        cmd_if.y_angle   = ya;
        cmd_if.z_angle   = za;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        pending_basis.push_back(predict_basis(op, xa, ya, za));
        @(negedge clk);
    endtask

    // Stops offering requests and waits until every expected result is back.
    task automatic wait_drained();
        cmd_if.valid = 1'b0;
        while (pending_basis.size() != 0)
            @(negedge clk);
    endtask

    task automatic compare_component(input string name,
                                     input logic signed [15:0] want,
                                     input logic signed [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Field extremes, pitch clamping, quadrant edges and wrapping of large angles.
    task automatic run_corner_requests();
        issue_request(OP_SET, 16'sd0, 16'sd0, 16'sd0);
        issue_request(OP_SET, 16'sd5760, 16'sd2880, 16'sd100);
        issue_request(OP_SET, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        issue_request(OP_SET, 16'sh8000, 16'sh8000, 16'sh8000);
        issue_request(OP_SET_CLAMP, 16'sd1000, 16'sh7FFF, -16'sd5);
        issue_request(OP_SET_CLAMP, -16'sd1000, 16'sh8000, 16'sd5);
        issue_request(OP_SET_CLAMP, 16'sd11520, 16'sd5696, 16'sd0);
        issue_request(OP_SET_CLAMP, 16'sd17280, 16'sd5697, 16'sd0);
        issue_request(OP_SET_CLAMP, -16'sd5760, -16'sd5697, 16'sd0);
        issue_request(OP_SET, 16'sd23039, -16'sd5760, 16'sd0);
        issue_request(OP_SET, -16'sd23040, 16'sd5760, 16'sd1);
        issue_request(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Roll saturation at both ends; the unused selector must leave everything alone.
    task automatic run_roll_saturation();
        issue_request(OP_SET, 16'sd2000, -16'sd1000, 16'sd0);
        issue_request(OP_ROTATE, 16'($urandom), 16'($urandom), 16'sh7FFF);
        issue_request(OP_ROTATE, 16'($urandom), 16'($urandom), 16'sd1);
        issue_request(OP_ROTATE, 16'($urandom), 16'($urandom), 16'sh8000);
        issue_request(OP_ROTATE, 16'($urandom), 16'($urandom), 16'sh8000);
        issue_request(OP_ROTATE, 16'($urandom), 16'($urandom), -16'sd1);
        issue_request(OP_ROTATE, 16'($urandom), 16'($urandom), 16'sd0);
        issue_request(OP_UNUSED, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    endtask

    // Random requests under the given idling of sender and receiver.
    task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
        int         pick;
        logic [1:0] op;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        repeat (count)
        begin
            pick = $urandom_range(19);
            if (pick < 7)
                op = OP_SET;
            else if (pick < 12)
                op = OP_SET_CLAMP;
            else if (pick < 19)
                op = OP_ROTATE;
            else
                op = OP_UNUSED;
            issue_request(op, pick_angle(), pick_angle(), pick_angle());
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic run_output_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        cmd_if.valid = 1'b0;
        @(posedge clk);
        recv_hold = 300;
        @(negedge clk);
        repeat (8)
            issue_request(OP_SET, pick_angle(), pick_angle(), pick_angle());
        wait_drained();
    endtask

    // The sender pauses until the block has handed back everything.
    task automatic run_paused_sender();
        send_gap_pct = 10;
        recv_gap_pct = 30;
        repeat (5)
            issue_request(OP_ROTATE, pick_angle(), pick_angle(), pick_angle());
        wait_drained();
        repeat (5)
            issue_request(OP_SET_CLAMP, pick_angle(), pick_angle(), pick_angle());
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        basis_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                basis_if.ready = 1'b0;
            else if (recv_hold > 0)
            begin
                basis_if.ready = 1'b0;
                recv_hold--;
            end
            else
                basis_if.ready = ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Checks each accepted result against the oldest expectation.
    initial
    begin
        basis_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && basis_if.valid && basis_if.ready)
            begin
                if (pending_basis.size() == 0)
                begin
                    $error("result accepted with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_basis.pop_front();
                    compare_component("front_x", want.front_x, basis_if.front_x);
                    compare_component("front_y", want.front_y, basis_if.front_y);
                    compare_component("front_z", want.front_z, basis_if.front_z);
                    compare_component("right_x", want.right_x, basis_if.right_x);
                    compare_component("right_y", want.right_y, basis_if.right_y);
                    compare_component("right_z", want.right_z, basis_if.right_z);
                    compare_component("up_x", want.up_x, basis_if.up_x);
                    compare_component("up_y", want.up_y, basis_if.up_y);
                    compare_component("up_z", want.up_z, basis_if.up_z);
                    compare_component("roll_now", want.roll_now, basis_if.roll_now);
                end
            end
        end
    end

    // Reset, then the tests in turn.
    initial
    begin
        rst_n            = 1'b0;
        fail_count       = 0;
        send_gap_pct     = 0;
        recv_gap_pct     = 0;
        recv_hold        = 0;
        yaw_q            = '0;
        pitch_q          = '0;
        roll_q           = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_SET;
        cmd_if.x_angle   = '0;
        cmd_if.y_angle   = '0;
        cmd_if.z_angle   = '0;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_corner_requests();
        run_roll_saturation();
        run_output_backpressure();
        run_paused_sender();
        run_random_phase(300, 34, 74);
        run_random_phase(300, 74, 34);
        run_random_phase(300, 0, 0);

        wait_drained();
        repeat (2 * STEPS + 40)
            @(negedge clk);
        if (pending_basis.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_basis.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
